### src/knn_binary_classifier_top_defines.svh
// Assertion macros shared by the classifier modules
`ifndef KNN_BINARY_CLASSIFIER_TOP_DEFINES_SVH
`define KNN_BINARY_CLASSIFIER_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define KNN_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset
`define KNN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### src/knn_pkg.sv
// Shared types and constants of the k-nearest-neighbour classifier
`default_nettype none

package knn_pkg;

  localparam int RATE_W   = 13;
  localparam int INST_W   = 28;
  localparam int PUB_W    = 4;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 3;
  localparam int TOTAL_W  = 32;
  localparam int K_W      = 4;
  localparam int REC_W    = RATE_W + INST_W + PUB_W + 1;

  localparam logic [K_W-1:0]     K_RESET   = 4'd5;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  localparam int STORE_DEPTH_DEF   = 1024;
  localparam int MAX_NEIGHBORS_DEF = 15;
  localparam int FRACTION_BITS_DEF = 12;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_CLEARED    = 3'd0,
    ST_STORED     = 3'd1,
    ST_FULL       = 3'd2,
    ST_CLASSIFIED = 3'd3,
    ST_EMPTY      = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_APPLY,
    S_SCAN,
    S_DRAIN,
    S_VOTE,
    S_POST,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic capture;
    logic start_query;
    logic apply;
    logic issue;
    logic vote;
    logic post;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic store_empty;
    logic last_issue;
    logic pipe_empty;
  } ctrl_stat_t;

endpackage

`default_nettype wire

### src/knn_binary_classifier_top.sv
// k-nearest-neighbour binary classifier: top level
//
// Training records are appended one per request into a RAM store; a query
// scans every stored record once, one RAM read per cycle, through a four-stage
// distance pipeline (read, difference, square, sum) into a sorted list of the
// k best lanes, then votes. A clear, an append or a query of an empty store
// goes from the apply state to the emit state; a query of a filled store goes
// through scan, drain, vote, post and emit; the store has one read port. One
// request is worked on at a time; a new request is taken while the last result
// still waits at the output. The store needs no clearing pass after reset.
`default_nettype none

module knn_binary_classifier_top #(
  parameter int STORE_DEPTH   = knn_pkg::STORE_DEPTH_DEF,
  parameter int MAX_NEIGHBORS = knn_pkg::MAX_NEIGHBORS_DEF,
  parameter int FRACTION_BITS = knn_pkg::FRACTION_BITS_DEF,
  parameter int CW            = $clog2(STORE_DEPTH + 1)
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [knn_pkg::K_W-1:0]       cfg_wdata,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [knn_pkg::OP_W-1:0]      operation,
  input  wire logic [knn_pkg::RATE_W-1:0]    rate,
  input  wire logic [knn_pkg::INST_W-1:0]    installment,
  input  wire logic [knn_pkg::PUB_W-1:0]     public_records,
  input  wire logic                          label,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [knn_pkg::STATUS_W-1:0]  status,
  output logic                               predicted_class,
  output logic                               prediction_correct,
  output logic      [CW-1:0]                 stored_total,
  output logic      [knn_pkg::TOTAL_W-1:0]   queries_total,
  output logic      [knn_pkg::TOTAL_W-1:0]   correct_total
);

  knn_pkg::ctrl_cmd_t  cmd;
  knn_pkg::ctrl_stat_t stat;

  knn_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  knn_datapath #(
    .STORE_DEPTH   (STORE_DEPTH),
    .MAX_NEIGHBORS (MAX_NEIGHBORS),
    .FRACTION_BITS (FRACTION_BITS),
    .CW            (CW)
  ) u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .stat               (stat),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .operation          (operation),
    .rate               (rate),
    .installment        (installment),
    .public_records     (public_records),
    .label              (label),
    .status             (status),
    .predicted_class    (predicted_class),
    .prediction_correct (prediction_correct),
    .stored_total       (stored_total),
    .queries_total      (queries_total),
    .correct_total      (correct_total)
  );

endmodule

`default_nettype wire

### src/knn_ram.sv
// Generic single-write, single-read RAM with registered read data
`default_nettype none

module knn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### src/knn_datapath.sv
// Datapath: record store, distance pipeline, sorted neighbour list, vote and counters
`default_nettype none
`include "knn_binary_classifier_top_defines.svh"

module knn_datapath #(
  parameter int STORE_DEPTH   = knn_pkg::STORE_DEPTH_DEF,
  parameter int MAX_NEIGHBORS = knn_pkg::MAX_NEIGHBORS_DEF,
  parameter int FRACTION_BITS = knn_pkg::FRACTION_BITS_DEF,
  parameter int CW            = $clog2(STORE_DEPTH + 1)
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire knn_pkg::ctrl_cmd_t            cmd,
  output knn_pkg::ctrl_stat_t                stat,
  input  wire logic                          cfg_we,
  input  wire logic [knn_pkg::K_W-1:0]       cfg_wdata,
  input  wire logic [knn_pkg::OP_W-1:0]      operation,
  input  wire logic [knn_pkg::RATE_W-1:0]    rate,
  input  wire logic [knn_pkg::INST_W-1:0]    installment,
  input  wire logic [knn_pkg::PUB_W-1:0]     public_records,
  input  wire logic                          label,
  output logic      [knn_pkg::STATUS_W-1:0]  status,
  output logic                               predicted_class,
  output logic                               prediction_correct,
  output logic      [CW-1:0]                 stored_total,
  output logic      [knn_pkg::TOTAL_W-1:0]   queries_total,
  output logic      [knn_pkg::TOTAL_W-1:0]   correct_total
);

  localparam int AW     = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int KW     = $clog2(MAX_NEIGHBORS + 1);
  localparam int MW0    = (CW > KW) ? CW : KW;
  localparam int MW     = (MW0 > knn_pkg::K_W) ? MW0 : knn_pkg::K_W;
  localparam int SQ_I   = 2 * knn_pkg::INST_W;
  localparam int SQ_P   = 2 * (knn_pkg::PUB_W + FRACTION_BITS);
  localparam int DISTW  = ((SQ_I > SQ_P) ? SQ_I : SQ_P) + 2;
  localparam int RSQ_W  = 2 * knn_pkg::RATE_W;
  localparam int ISQ_W  = 2 * knn_pkg::INST_W;
  localparam int PSQ_W  = 2 * knn_pkg::PUB_W;

  // request held for the whole operation
  knn_pkg::op_t                  op_q;
  logic [knn_pkg::RATE_W-1:0]    rate_q;
  logic [knn_pkg::INST_W-1:0]    inst_q;
  logic [knn_pkg::PUB_W-1:0]     pub_q;
  logic                          label_q;

  logic [knn_pkg::K_W-1:0]       k_reg;
  logic [CW-1:0]                 stored_count;
  logic [knn_pkg::TOTAL_W-1:0]   query_count;
  logic [knn_pkg::TOTAL_W-1:0]   correct_count;
  logic [CW-1:0]                 scan_idx;
  logic [KW-1:0]                 keff;

  knn_pkg::status_t              status_q;
  logic                          pred_q;
  logic                          ok_q;

  logic                          store_full;
  logic                          ram_we;
  logic [knn_pkg::REC_W-1:0]     rd_rec;

  logic                          v1, v2, v3, v4;
  logic [knn_pkg::RATE_W-1:0]    rdiff;
  logic [knn_pkg::INST_W-1:0]    idiff;
  logic [knn_pkg::PUB_W-1:0]     pdiff;
  logic                          lab2, lab3, lab4;
  logic [RSQ_W-1:0]              rsq;
  logic [ISQ_W-1:0]              isq;
  logic [PSQ_W-1:0]              psq;
  logic [DISTW-1:0]              dist4;

  logic [DISTW-1:0]              best_d [MAX_NEIGHBORS];
  logic                          best_l [MAX_NEIGHBORS];
  logic                          best_v [MAX_NEIGHBORS];
  logic                          keep   [MAX_NEIGHBORS];

  logic [KW-1:0]                 ones_q, have_q, ones_n, have_n;
  logic                          pred_n;

  logic [MW-1:0]                 k1, kclamp, keff_n;

  logic [knn_pkg::RATE_W-1:0]    rd_rate;
  logic [knn_pkg::INST_W-1:0]    rd_inst;
  logic [knn_pkg::PUB_W-1:0]     rd_pub;
  logic                          rd_lab;

  assign store_full = (stored_count == CW'(STORE_DEPTH));
  assign ram_we     = cmd.apply && (op_q == knn_pkg::OP_APPEND) && !store_full;

  assign stat.store_empty = (stored_count == '0);
  assign stat.last_issue  = ((scan_idx + CW'(1)) == stored_count);
  assign stat.pipe_empty  = !(v1 || v2 || v3 || v4);

  knn_ram #(
    .WIDTH (knn_pkg::REC_W),
    .DEPTH (STORE_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (stored_count[AW-1:0]),
    .wdata ({rate_q, inst_q, pub_q, label_q}),
    .raddr (scan_idx[AW-1:0]),
    .rdata (rd_rec)
  );

  assign {rd_rate, rd_inst, rd_pub, rd_lab} = rd_rec;

  // k: zero means one, then capped by the list length and the records held
  always_comb begin
    k1     = (k_reg == '0) ? MW'(1) : MW'(k_reg);
    kclamp = (k1 > MW'(MAX_NEIGHBORS)) ? MW'(MAX_NEIGHBORS) : k1;
    keff_n = (kclamp > MW'(stored_count)) ? MW'(stored_count) : kclamp;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q    <= knn_pkg::op_t'(operation);
      rate_q  <= rate;
      inst_q  <= installment;
      pub_q   <= public_records;
      label_q <= label;
    end
    if (cmd.start_query) begin
      keff <= KW'(keff_n);
    end
    if (cmd.issue) begin
      scan_idx <= scan_idx + CW'(1);
    end else if (cmd.start_query) begin
      scan_idx <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k_reg         <= knn_pkg::K_RESET;
      stored_count  <= '0;
      query_count   <= '0;
      correct_count <= '0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (cfg_we) begin
        k_reg <= cfg_wdata;
      end
      v1 <= cmd.issue;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      if (cmd.apply) begin
        if (op_q == knn_pkg::OP_CLEAR) begin
          stored_count  <= '0;
          query_count   <= '0;
          correct_count <= '0;
        end else if (ram_we) begin
          stored_count <= stored_count + CW'(1);
        end
      end
      if (cmd.post) begin
        if (query_count != knn_pkg::TOTAL_MAX) begin
          query_count <= query_count + knn_pkg::TOTAL_W'(1);
        end
        if ((pred_n == label_q) && (correct_count != knn_pkg::TOTAL_MAX)) begin
          correct_count <= correct_count + knn_pkg::TOTAL_W'(1);
        end
      end
    end
  end

  // distance pipeline: difference, square, sum
  always_ff @(posedge clk) begin
    rdiff <= (rd_rate > rate_q) ? (rd_rate - rate_q) : (rate_q - rd_rate);
    idiff <= (rd_inst > inst_q) ? (rd_inst - inst_q) : (inst_q - rd_inst);
    pdiff <= (rd_pub > pub_q) ? (rd_pub - pub_q) : (pub_q - rd_pub);
    lab2  <= rd_lab;
    rsq   <= RSQ_W'(rdiff) * RSQ_W'(rdiff);
    isq   <= ISQ_W'(idiff) * ISQ_W'(idiff);
    psq   <= PSQ_W'(pdiff) * PSQ_W'(pdiff);
    lab3  <= lab2;
    dist4 <= DISTW'(rsq) + DISTW'(isq) + (DISTW'(psq) << (2 * FRACTION_BITS));
    lab4  <= lab3;
  end

  // sorted list: lanes holding a distance not above the new one stay,
  // the first other lane takes the new record, the rest move down one
  genvar g;
  generate
    for (g = 0; g < MAX_NEIGHBORS; g++) begin : g_lane
      logic in_range;
      logic at_pos;
      assign keep[g]  = best_v[g] && (best_d[g] <= dist4);
      assign in_range = (KW'(g) < keff);
      if (g == 0) begin : g_first
        assign at_pos = 1'b1;
      end else begin : g_rest
        assign at_pos = keep[g-1];
      end

      always_ff @(posedge clk) begin
        if (cmd.start_query) begin
          best_v[g] <= 1'b0;
        end else if (v4 && !keep[g] && in_range) begin
          if (at_pos) begin
            best_d[g] <= dist4;
            best_l[g] <= lab4;
            best_v[g] <= 1'b1;
          end else begin
            if (g > 0) begin
              best_d[g] <= best_d[(g > 0) ? g - 1 : 0];
              best_l[g] <= best_l[(g > 0) ? g - 1 : 0];
              best_v[g] <= best_v[(g > 0) ? g - 1 : 0];
            end
          end
        end
      end
    end
  endgenerate

  always_comb begin
    ones_n = '0;
    have_n = '0;
    for (int j = 0; j < MAX_NEIGHBORS; j++) begin
      have_n = have_n + KW'(best_v[j]);
      ones_n = ones_n + KW'(best_v[j] && best_l[j]);
    end
  end

  // class 0 only with a strict majority of zeros
  assign pred_n = ({1'b0, have_q} <= {ones_q, 1'b0});

  always_ff @(posedge clk) begin
    if (cmd.vote) begin
      ones_q <= ones_n;
      have_q <= have_n;
    end
    if (cmd.apply) begin
      pred_q <= 1'b0;
      ok_q   <= 1'b0;
      unique case (op_q)
        knn_pkg::OP_CLEAR:  status_q <= knn_pkg::ST_CLEARED;
        knn_pkg::OP_APPEND: status_q <= store_full ? knn_pkg::ST_FULL : knn_pkg::ST_STORED;
        knn_pkg::OP_QUERY:  status_q <= knn_pkg::ST_EMPTY;
        default:            status_q <= status_q;
      endcase
    end else if (cmd.post) begin
      status_q <= knn_pkg::ST_CLASSIFIED;
      pred_q   <= pred_n;
      ok_q     <= (pred_n == label_q);
    end
    if (cmd.load_out) begin
      status             <= status_q;
      predicted_class    <= pred_q;
      prediction_correct <= ok_q;
      stored_total       <= stored_count;
      queries_total      <= query_count;
      correct_total      <= correct_count;
    end
  end

  `KNN_ASSERT_NOW(a_store_bound, 1'b1, stored_count <= CW'(STORE_DEPTH), "store count overrun")
  `KNN_ASSERT_NOW(a_correct_le_queries, 1'b1, correct_count <= query_count, "correct above queries")
  `KNN_ASSERT_NOW(a_list_within_k, cmd.vote, have_n <= keff, "neighbour list above k")

endmodule

`default_nettype wire

### src/knn_ctrl.sv
// Controller: sequences clear, append and query scan, owns the handshakes
`default_nettype none
`include "knn_binary_classifier_top_defines.svh"

module knn_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [knn_pkg::OP_W-1:0]  operation,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output knn_pkg::ctrl_cmd_t             cmd,
  input  wire knn_pkg::ctrl_stat_t       stat
);

  knn_pkg::state_t state, state_next;
  logic            accept;
  logic            out_free;
  logic            out_valid_next;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    unique case (state)
      knn_pkg::S_IDLE: begin
        if (accept) begin
          priority if (operation == knn_pkg::OP_NONE) begin
            state_next = knn_pkg::S_IDLE;
          end else if ((operation == knn_pkg::OP_QUERY) && !stat.store_empty) begin
            state_next = knn_pkg::S_SCAN;
          end else begin
            state_next = knn_pkg::S_APPLY;
          end
        end
      end
      knn_pkg::S_APPLY: state_next = knn_pkg::S_EMIT;
      knn_pkg::S_SCAN:  if (stat.last_issue) state_next = knn_pkg::S_DRAIN;
      knn_pkg::S_DRAIN: if (stat.pipe_empty) state_next = knn_pkg::S_VOTE;
      knn_pkg::S_VOTE:  state_next = knn_pkg::S_POST;
      knn_pkg::S_POST:  state_next = knn_pkg::S_EMIT;
      knn_pkg::S_EMIT:  if (out_free) state_next = knn_pkg::S_IDLE;
      default:          state_next = knn_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_stall        = (state != knn_pkg::S_IDLE);
    cmd             = '0;
    cmd.capture     = accept;
    cmd.start_query = accept && (operation == knn_pkg::OP_QUERY) && !stat.store_empty;
    cmd.apply       = (state == knn_pkg::S_APPLY);
    cmd.issue       = (state == knn_pkg::S_SCAN);
    cmd.vote        = (state == knn_pkg::S_VOTE);
    cmd.post        = (state == knn_pkg::S_POST);
    cmd.load_out    = (state == knn_pkg::S_EMIT) && out_free;
    out_valid_next  = cmd.load_out || (out_valid && out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= knn_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  `KNN_ASSERT_NOW(a_scan_nonempty, cmd.issue, !stat.store_empty, "scan of empty store")
  `KNN_ASSERT_NOW(a_idle_drained, state == knn_pkg::S_IDLE, stat.pipe_empty, "pipe busy in idle")
  `KNN_ASSERT_NEXT(a_emit_shows, cmd.load_out, out_valid, "result not presented")

endmodule

`default_nettype wire
